[rtl/pdt_pkg.sv]
`default_nettype none

package pdt_pkg;

    // Default widths of the time and count paths.
    localparam int TIME_WIDTH_DEF  = 64;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int CMD_W  = 3;
    localparam int DEN_W  = 8;
    localparam int CB_W   = 17;
    localparam int LEAD_W = 20;
    localparam int WIN_W  = 32;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register reset values.
    localparam logic [LEAD_W-1:0] MIN_LEAD_RST = LEAD_W'(10000);
    localparam logic [WIN_W-1:0]  WINDOW_RST   = WIN_W'(200 * 1000000);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXPIRY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DISC   = 3'd4;

    // Register indexes (word address).
    localparam logic [1:0] REG_HW_PERIODIC = 2'd0;
    localparam logic [1:0] REG_MIN_LEAD    = 2'd1;
    localparam logic [1:0] REG_WINDOW      = 2'd2;

    // Count reported on a clock discontinuity.
    localparam logic [CB_W-1:0] CB_DISC = '1;

    typedef struct packed {
        logic              hw_periodic_mode;
        logic [LEAD_W-1:0] min_lead_ns;
        logic [WIN_W-1:0]  window_ns;
    } cfg_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START_CHK,
        OP_START_ARM,
        OP_SCAN_EXP,
        OP_SCAN_PROG,
        OP_SCAN_WAKE,
        OP_EXP_CHK,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_ROUND,
        OP_ADD_ROUND,
        OP_ADVANCE,
        OP_RELOAD,
        OP_PROG,
        OP_HALT,
        OP_DISC,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ready;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad_den;
        logic             past;
        logic             pending;
        logic             in_window;
        logic             scan_stop;
        logic             armed;
        logic             late;
        logic             d_ge_per;
        logic             div_last;
        logic             reload;
        logic             hw;
        logic             out_busy;
    } sts_t;

endpackage

`default_nettype wire

[rtl/pdt_if.sv]
`default_nettype none

// Command channel.
interface pdt_cmd_if #(parameter int TIME_WIDTH = pdt_pkg::TIME_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic [pdt_pkg::CMD_W-1:0]    command;
    logic [TIME_WIDTH-1:0]        now;
    logic [TIME_WIDTH-1:0]        value;
    logic [TIME_WIDTH-1:0]        period;
    logic [pdt_pkg::DEN_W-1:0]    period_denominator;
    logic                         absolute;

    modport source (output valid, command, now, value, period, period_denominator, absolute,
                    input ready);
    modport sink   (input valid, command, now, value, period, period_denominator, absolute,
                    output ready);
endinterface

// Result channel.
interface pdt_res_if #(parameter int TIME_WIDTH = pdt_pkg::TIME_WIDTH_DEF);
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic                            program_valid;
    logic [TIME_WIDTH-1:0]           program_time;
    logic                            program_periodic;
    logic [TIME_WIDTH-1:0]           program_period;
    logic                            compare_cancel;
    logic                            wake_valid;
    logic [TIME_WIDTH-1:0]           wake_delay;
    logic                            callback_valid;
    logic signed [pdt_pkg::CB_W-1:0] callback_count;

    modport source (output valid, status, program_valid, program_time, program_periodic,
                    program_period, compare_cancel, wake_valid, wake_delay,
                    callback_valid, callback_count,
                    input ready);
    modport sink   (input valid, status, program_valid, program_time, program_periodic,
                    program_period, compare_cancel, wake_valid, wake_delay,
                    callback_valid, callback_count,
                    output ready);
endinterface

`default_nettype wire

[rtl/pdt_regs.sv]
`default_nettype none

module pdt_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pdt_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pdt_pkg::DATA_W-1:0]   pwdata,
    output logic      [pdt_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output pdt_pkg::cfg_t                     cfg
);

    pdt_pkg::cfg_t cfg_reg;
    pdt_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                pdt_pkg::REG_HW_PERIODIC: cfg_next.hw_periodic_mode = pwdata[0];
                pdt_pkg::REG_MIN_LEAD:    cfg_next.min_lead_ns = pwdata[pdt_pkg::LEAD_W-1:0];
                pdt_pkg::REG_WINDOW:      cfg_next.window_ns   = pwdata[pdt_pkg::WIN_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (paddr[3:2])
            pdt_pkg::REG_HW_PERIODIC: prdata = pdt_pkg::DATA_W'(cfg_reg.hw_periodic_mode);
            pdt_pkg::REG_MIN_LEAD:    prdata = pdt_pkg::DATA_W'(cfg_reg.min_lead_ns);
            pdt_pkg::REG_WINDOW:      prdata = pdt_pkg::DATA_W'(cfg_reg.window_ns);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hw_periodic_mode <= 1'b0;
            cfg_reg.min_lead_ns      <= pdt_pkg::MIN_LEAD_RST;
            cfg_reg.window_ns        <= pdt_pkg::WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/pdt_ctrl.sv]
`default_nettype none

module pdt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  pdt_pkg::sts_t      sts,
    output pdt_pkg::ctl_t      ctl
);

    typedef enum logic [17:0] {
        ST_IDLE       = 18'b000000000000000001,
        ST_DECODE     = 18'b000000000000000010,
        ST_START_CHK  = 18'b000000000000000100,
        ST_START_ARM  = 18'b000000000000001000,
        ST_SCAN_EXP   = 18'b000000000000010000,
        ST_SCAN_PROG  = 18'b000000000000100000,
        ST_SCAN_WAKE  = 18'b000000000001000000,
        ST_EXP_CHK    = 18'b000000000010000000,
        ST_EXP_CMP    = 18'b000000000100000000,
        ST_DIV        = 18'b000000001000000000,
        ST_ROUND      = 18'b000000010000000000,
        ST_ADD_ROUND  = 18'b000000100000000000,
        ST_ADVANCE    = 18'b000001000000000000,
        ST_RELOAD     = 18'b000010000000000000,
        ST_PROG       = 18'b000100000000000000,
        ST_HALT       = 18'b001000000000000000,
        ST_DISC       = 18'b010000000000000000,
        ST_PUBLISH    = 18'b100000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE:
                if (req_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
                unique case (sts.cmd)
                    pdt_pkg::CMD_START:  state_next = ST_START_CHK;
                    pdt_pkg::CMD_STOP:   state_next = ST_HALT;
                    pdt_pkg::CMD_SCAN:   state_next = ST_SCAN_EXP;
                    pdt_pkg::CMD_EXPIRY: state_next = ST_EXP_CHK;
                    pdt_pkg::CMD_DISC:   state_next = ST_DISC;
                    default:             state_next = ST_PUBLISH;
                endcase
            ST_START_CHK:
                state_next = sts.bad_den ? ST_PUBLISH : ST_START_ARM;
            ST_START_ARM:
                state_next = sts.past ? ST_PUBLISH : ST_SCAN_EXP;
            ST_SCAN_EXP:
                state_next = sts.pending ? ST_SCAN_PROG : ST_PUBLISH;
            ST_SCAN_PROG:
                state_next = (sts.in_window && sts.scan_stop) ? ST_PUBLISH : ST_SCAN_WAKE;
            ST_SCAN_WAKE:
                state_next = ST_PUBLISH;
            ST_EXP_CHK:
                if (!sts.armed)
                    state_next = ST_PUBLISH;
                else if (sts.late)
                    state_next = ST_EXP_CMP;
                else
                    state_next = ST_RELOAD;
            ST_EXP_CMP:
                state_next = sts.d_ge_per ? ST_DIV : ST_RELOAD;
            ST_DIV:
                if (sts.div_last)
                    state_next = ST_ROUND;
            ST_ROUND:
                state_next = ST_ADD_ROUND;
            ST_ADD_ROUND:
                state_next = ST_ADVANCE;
            ST_ADVANCE:
                state_next = ST_RELOAD;
            ST_RELOAD:
                state_next = (sts.reload && !sts.hw) ? ST_PROG : ST_PUBLISH;
            ST_PROG, ST_HALT, ST_DISC:
                state_next = ST_PUBLISH;
            ST_PUBLISH:
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Operation issued in each state.
    always_comb
    begin
        ctl.ready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:      ctl.op = pdt_pkg::OP_LOAD;
            ST_DECODE:    ctl.op = pdt_pkg::OP_NONE;
            ST_START_CHK: ctl.op = pdt_pkg::OP_START_CHK;
            ST_START_ARM: ctl.op = pdt_pkg::OP_START_ARM;
            ST_SCAN_EXP:  ctl.op = pdt_pkg::OP_SCAN_EXP;
            ST_SCAN_PROG: ctl.op = pdt_pkg::OP_SCAN_PROG;
            ST_SCAN_WAKE: ctl.op = pdt_pkg::OP_SCAN_WAKE;
            ST_EXP_CHK:   ctl.op = pdt_pkg::OP_EXP_CHK;
            ST_EXP_CMP:   ctl.op = pdt_pkg::OP_DIV_LOAD;
            ST_DIV:       ctl.op = pdt_pkg::OP_DIV_STEP;
            ST_ROUND:     ctl.op = pdt_pkg::OP_ROUND;
            ST_ADD_ROUND: ctl.op = pdt_pkg::OP_ADD_ROUND;
            ST_ADVANCE:   ctl.op = pdt_pkg::OP_ADVANCE;
            ST_RELOAD:    ctl.op = pdt_pkg::OP_RELOAD;
            ST_PROG:      ctl.op = pdt_pkg::OP_PROG;
            ST_HALT:      ctl.op = pdt_pkg::OP_HALT;
            ST_DISC:      ctl.op = pdt_pkg::OP_DISC;
            ST_PUBLISH:   ctl.op = pdt_pkg::OP_PUBLISH;
            default:      ctl.op = pdt_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[rtl/pdt_dp.sv]
`default_nettype none

module pdt_dp #(
    parameter int TIME_WIDTH  = pdt_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = pdt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  pdt_pkg::cfg_t  cfg,
    input  pdt_pkg::ctl_t  ctl,
    output pdt_pkg::sts_t  sts,
    pdt_cmd_if.sink        request,
    pdt_res_if.source      result
);

    localparam int TW    = TIME_WIDTH;
    localparam int CNT_W = $clog2(TW);
    localparam longint unsigned CW_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [COUNT_WIDTH-1:0] CNT_SAT =
        COUNT_WIDTH'((CW_MAX < 64'd65535) ? CW_MAX : 64'd65535);

    // Latched command.
    logic [pdt_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [TW-1:0]             now_reg, now_next;
    logic [TW-1:0]             val_reg, val_next;
    logic [TW-1:0]             per_reg, per_next;
    logic [pdt_pkg::DEN_W-1:0] den_reg, den_next;
    logic                      abs_reg, abs_next;

    // Timer state.
    logic [TW-1:0] nd_reg, nd_next;
    logic [TW-1:0] cd_reg, cd_next;
    logic [TW-1:0] pr_reg, pr_next;
    logic          reload_reg, reload_next;
    logic          armed_reg, armed_next;
    logic          pending_reg, pending_next;

    // Scratch values and the serial divider.
    logic [TW-1:0]          exp_reg, exp_next;
    logic [TW-1:0]          d_reg, d_next;
    logic [TW-1:0]          quo_reg, quo_next;
    logic [TW:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [TW-1:0]          np_reg, np_next;
    logic [TW-1:0]          n_reg, n_next;
    logic                   rnd_reg, rnd_next;
    logic [COUNT_WIDTH-1:0] rc_reg, rc_next;

    // Result under construction.
    logic                      w_st_reg, w_st_next;
    logic                      w_pv_reg, w_pv_next;
    logic [TW-1:0]             w_pt_reg, w_pt_next;
    logic                      w_pp_reg, w_pp_next;
    logic [TW-1:0]             w_ppd_reg, w_ppd_next;
    logic                      w_cc_reg, w_cc_next;
    logic                      w_wv_reg, w_wv_next;
    logic [TW-1:0]             w_wd_reg, w_wd_next;
    logic                      w_cv_reg, w_cv_next;
    logic [pdt_pkg::CB_W-1:0]  w_cb_reg, w_cb_next;

    // Output holding register.
    logic                      o_valid_reg, o_valid_next;
    logic                      o_st_reg, o_pv_reg, o_pp_reg, o_cc_reg, o_wv_reg, o_cv_reg;
    logic [TW-1:0]             o_pt_reg, o_ppd_reg, o_wd_reg;
    logic [pdt_pkg::CB_W-1:0]  o_cb_reg;
    logic                      publish;

    logic [TW-1:0] lead_ext;
    logic [TW-1:0] win_ext;
    logic [TW-1:0] nd_plus_per;
    logic [TW-1:0] now_plus_lead;
    logic [TW:0]   rem_shift;
    logic          rem_fits;

    assign lead_ext      = TW'(cfg.min_lead_ns);
    assign win_ext       = TW'(cfg.window_ns);
    assign nd_plus_per   = nd_reg + pr_reg;
    assign now_plus_lead = now_reg + lead_ext;
    assign rem_shift     = {rem_reg[TW-1:0], quo_reg[TW-1]};
    assign rem_fits      = rem_shift >= {1'b0, pr_reg};

    assign request.ready = ctl.ready;
    assign publish       = (ctl.op == pdt_pkg::OP_PUBLISH) && !sts.out_busy;

    // Status towards the controller.
    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.bad_den   = (per_reg != '0) && (den_reg != pdt_pkg::DEN_W'(1));
        sts.past      = abs_reg && (val_reg < now_reg);
        sts.pending   = pending_reg;
        sts.in_window = exp_reg <= win_ext;
        sts.scan_stop = (pr_reg == '0) || reload_reg || cfg.hw_periodic_mode;
        sts.armed     = armed_reg;
        sts.late      = (pr_reg != '0) && (now_reg >= cd_reg);
        sts.d_ge_per  = d_reg >= pr_reg;
        sts.div_last  = (cnt_reg == '0);
        sts.reload    = reload_reg;
        sts.hw        = cfg.hw_periodic_mode;
        sts.out_busy  = o_valid_reg && !result.ready;
    end

    // Datapath operations.
    always_comb
    begin
        cmd_next = cmd_reg;  now_next = now_reg;  val_next = val_reg;
        per_next = per_reg;  den_next = den_reg;  abs_next = abs_reg;
        nd_next = nd_reg;  cd_next = cd_reg;  pr_next = pr_reg;
        reload_next = reload_reg;  armed_next = armed_reg;  pending_next = pending_reg;
        exp_next = exp_reg;  d_next = d_reg;  quo_next = quo_reg;  rem_next = rem_reg;
        cnt_next = cnt_reg;  np_next = np_reg;  n_next = n_reg;  rnd_next = rnd_reg;
        rc_next = rc_reg;
        w_st_next = w_st_reg;  w_pv_next = w_pv_reg;  w_pt_next = w_pt_reg;
        w_pp_next = w_pp_reg;  w_ppd_next = w_ppd_reg;  w_cc_next = w_cc_reg;
        w_wv_next = w_wv_reg;  w_wd_next = w_wd_reg;  w_cv_next = w_cv_reg;
        w_cb_next = w_cb_reg;

        unique case (ctl.op) inside
            pdt_pkg::OP_LOAD:
                if (request.valid)
                begin
                    cmd_next = request.command;
                    now_next = request.now;
                    val_next = request.value;
                    per_next = request.period;
                    den_next = request.period_denominator;
                    abs_next = request.absolute;
                    w_st_next = 1'b0;  w_pv_next = 1'b0;  w_pt_next = '0;
                    w_pp_next = 1'b0;  w_ppd_next = '0;   w_cc_next = 1'b0;
                    w_wv_next = 1'b0;  w_wd_next = '0;    w_cv_next = 1'b0;
                    w_cb_next = '0;
                end
            pdt_pkg::OP_START_CHK:
                if (sts.bad_den)
                    w_st_next = 1'b1;
                else if (!cfg.hw_periodic_mode)
                    val_next = val_reg + per_reg;
            pdt_pkg::OP_START_ARM:
                if (sts.past)
                    w_st_next = 1'b1;
                else
                begin
                    // Stop the running timer, then arm with the new deadline.
                    if (armed_reg)
                    begin
                        armed_next = 1'b0;
                        w_cc_next  = 1'b1;
                    end
                    nd_next = abs_reg ? val_reg : (val_reg + now_reg);
                    pr_next = per_reg;
                    if (per_reg != '0)
                        reload_next = per_reg < win_ext;
                    pending_next = 1'b1;
                end
            pdt_pkg::OP_SCAN_EXP:
                if (pending_reg)
                    exp_next = (now_reg < nd_reg) ? (nd_reg - now_reg) : lead_ext;
            pdt_pkg::OP_SCAN_PROG:
                if (sts.in_window)
                begin
                    armed_next = 1'b1;
                    w_pv_next  = 1'b1;
                    w_pt_next  = (exp_reg <= lead_ext) ? now_plus_lead : nd_reg;
                    if (cfg.hw_periodic_mode)
                    begin
                        nd_next    = nd_plus_per;
                        cd_next    = nd_plus_per;
                        w_pp_next  = 1'b1;
                        w_ppd_next = pr_reg;
                    end
                    else
                    begin
                        cd_next = nd_reg;
                    end
                    if (sts.scan_stop)
                        pending_next = 1'b0;
                    else
                    begin
                        nd_next  = nd_plus_per;
                        exp_next = exp_reg + pr_reg;
                    end
                end
            pdt_pkg::OP_SCAN_WAKE:
            begin
                w_wv_next = 1'b1;
                w_wd_next = exp_reg - (win_ext >> 3);
            end
            pdt_pkg::OP_EXP_CHK:
            begin
                rc_next = COUNT_WIDTH'(1);
                d_next  = now_reg - cd_reg;
            end
            pdt_pkg::OP_DIV_LOAD:
            begin
                quo_next = d_reg;
                rem_next = '0;
                cnt_next = CNT_W'(TW - 1);
            end
            pdt_pkg::OP_DIV_STEP:
            begin
                // One restoring step per cycle, quotient bits shift in from the right.
                rem_next = rem_fits ? (rem_shift - {1'b0, pr_reg}) : rem_shift;
                quo_next = {quo_reg[TW-2:0], rem_fits};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            pdt_pkg::OP_ROUND:
            begin
                rnd_next = rem_reg[TW-1:0] >= (pr_reg - (pr_reg >> 1));
                n_next   = quo_reg + TW'(rem_reg[TW-1:0] >= (pr_reg - (pr_reg >> 1)));
                np_next  = d_reg - rem_reg[TW-1:0];
            end
            pdt_pkg::OP_ADD_ROUND:
                if (rnd_reg)
                    np_next = np_reg + pr_reg;
            pdt_pkg::OP_ADVANCE:
            begin
                cd_next = cd_reg + np_reg;
                nd_next = nd_reg + np_reg;
                rc_next = (n_reg >= TW'(CNT_SAT)) ? CNT_SAT : COUNT_WIDTH'(n_reg + TW'(1));
            end
            pdt_pkg::OP_RELOAD:
            begin
                if (cfg.hw_periodic_mode || reload_reg)
                begin
                    nd_next = nd_plus_per;
                    cd_next = nd_plus_per;
                end
                else
                begin
                    armed_next = 1'b0;
                end
                w_cv_next = 1'b1;
                w_cb_next = pdt_pkg::CB_W'(rc_reg);
            end
            pdt_pkg::OP_PROG:
            begin
                w_pv_next = 1'b1;
                w_pt_next = (nd_reg < now_plus_lead) ? now_plus_lead : nd_reg;
            end
            pdt_pkg::OP_HALT, pdt_pkg::OP_DISC:
            begin
                pending_next = 1'b0;
                if (armed_reg)
                begin
                    armed_next = 1'b0;
                    w_cc_next  = 1'b1;
                end
                if (ctl.op == pdt_pkg::OP_DISC)
                begin
                    w_cv_next = 1'b1;
                    w_cb_next = pdt_pkg::CB_DISC;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (o_valid_reg && result.ready)
            o_valid_next = 1'b0;
        if (publish)
            o_valid_next = 1'b1;
    end

    assign result.valid            = o_valid_reg;
    assign result.status           = o_st_reg;
    assign result.program_valid    = o_pv_reg;
    assign result.program_time     = o_pt_reg;
    assign result.program_periodic = o_pp_reg;
    assign result.program_period   = o_ppd_reg;
    assign result.compare_cancel   = o_cc_reg;
    assign result.wake_valid       = o_wv_reg;
    assign result.wake_delay       = o_wd_reg;
    assign result.callback_valid   = o_cv_reg;
    assign result.callback_count   = $signed(o_cb_reg);

    // Control state and timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg      <= '0;
            cd_reg      <= '0;
            pr_reg      <= '0;
            reload_reg  <= 1'b0;
            armed_reg   <= 1'b0;
            pending_reg <= 1'b0;
            cnt_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            nd_reg      <= nd_next;
            cd_reg      <= cd_next;
            pr_reg      <= pr_next;
            reload_reg  <= reload_next;
            armed_reg   <= armed_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;  now_reg <= now_next;  val_reg <= val_next;
        per_reg <= per_next;  den_reg <= den_next;  abs_reg <= abs_next;
        exp_reg <= exp_next;  d_reg <= d_next;  quo_reg <= quo_next;  rem_reg <= rem_next;
        np_reg <= np_next;  n_reg <= n_next;  rnd_reg <= rnd_next;  rc_reg <= rc_next;
        w_st_reg <= w_st_next;  w_pv_reg <= w_pv_next;  w_pt_reg <= w_pt_next;
        w_pp_reg <= w_pp_next;  w_ppd_reg <= w_ppd_next;  w_cc_reg <= w_cc_next;
        w_wv_reg <= w_wv_next;  w_wd_reg <= w_wd_next;  w_cv_reg <= w_cv_next;
        w_cb_reg <= w_cb_next;
        if (publish)
        begin
            o_st_reg  <= w_st_reg;
            o_pv_reg  <= w_pv_reg;
            o_pt_reg  <= w_pt_reg;
            o_pp_reg  <= w_pp_reg;
            o_ppd_reg <= w_ppd_reg;
            o_cc_reg  <= w_cc_reg;
            o_wv_reg  <= w_wv_reg;
            o_wd_reg  <= w_wd_reg;
            o_cv_reg  <= w_cv_reg;
            o_cb_reg  <= w_cb_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/periodic_deadline_timer.sv]
`default_nettype none

// Channel   | Role   | Transaction
// ----------+--------+-----------------------------------------------------------
// request   | sink   | valid & ready: one timer command with the current time
// result    | source | valid & ready: one result per command
// APB       | slave  | psel & penable & pwrite: register write, pready tied high
//
// Each command walks the sequencer states from acceptance to its result. An expiry
// with late periods also runs the restoring divider in the datapath, which yields
// one quotient bit per cycle.
// One command is in flight at a time; request.ready is high only when idle.
// The result sits in an output register; a stalled result holds the next
// command in its final step. Reset is asynchronous and clears the timer state.

module periodic_deadline_timer #(
    parameter int TIME_WIDTH  = pdt_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = pdt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pdt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pdt_pkg::DATA_W-1:0]  pwdata,
    output logic      [pdt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    pdt_cmd_if.sink                          request,
    pdt_res_if.source                        result
);

    pdt_pkg::cfg_t cfg;
    pdt_pkg::ctl_t ctl;
    pdt_pkg::sts_t sts;

    // Configuration registers.
    pdt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Command sequencer.
    pdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Timer state, arithmetic and result registers.
    pdt_dp #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .ctl     (ctl),
        .sts     (sts),
        .request (request),
        .result  (result)
    );

endmodule

`default_nettype wire

[rtl/pdt_checker.sv]
`default_nettype none

module pdt_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            res_valid,
    input wire logic                            res_ready,
    input wire logic                            status,
    input wire logic                            program_valid,
    input wire logic                            program_periodic,
    input wire logic                            compare_cancel,
    input wire logic                            wake_valid,
    input wire logic                            callback_valid,
    input wire logic signed [pdt_pkg::CB_W-1:0] callback_count
);

    // Only one command is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a command is in flight");

    // A waiting result stays valid and keeps its callback count.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(callback_count))
        else $error("stalled result changed");

    // A rejected start reports nothing else.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status |->
            !program_valid && !compare_cancel && !wake_valid && !callback_valid)
        else $error("rejected start carries other fields");

    // A hardware-periodic compare is always a programmed compare.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && program_periodic |-> program_valid)
        else $error("periodic compare without programming");

    // The count is zero when no callback is issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !callback_valid |-> callback_count == '0)
        else $error("count without callback");

endmodule

bind periodic_deadline_timer pdt_checker u_pdt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (request.valid),
    .req_ready        (request.ready),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .status           (result.status),
    .program_valid    (result.program_valid),
    .program_periodic (result.program_periodic),
    .compare_cancel   (result.compare_cancel),
    .wake_valid       (result.wake_valid),
    .callback_valid   (result.callback_valid),
    .callback_count   (result.callback_count)
);

`default_nettype wire

[tb/sv/pdt_checker.sv]
`timescale 1ns / 100ps

// Watches the register port and both channels, keeps a model of the timer
// and checks every result transaction against the expected outcome.
module pdt_scoreboard (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pdt_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pdt_pkg::DATA_W-1:0]   pwdata,
    input  wire logic                         pready,
    pdt_cmd_if                                request,
    pdt_res_if                                result,
    output int                                outstanding,
    output int                                mismatches
);

    localparam logic [63:0] COUNT_SAT = 64'd65535;

    typedef struct packed {
        logic        status;
        logic        program_valid;
        logic [63:0] program_time;
        logic        program_periodic;
        logic [63:0] program_period;
        logic        compare_cancel;
        logic        wake_valid;
        logic [63:0] wake_delay;
        logic        callback_valid;
        logic [16:0] callback_count;
    } outcome_t;

    outcome_t outcome_q[$];

    // Register copies.
    logic                       hw_mode;
    logic [pdt_pkg::LEAD_W-1:0] lead;
    logic [pdt_pkg::WIN_W-1:0]  win;

    // Timer state.
    logic [63:0] next_dl;
    logic [63:0] cur_dl;
    logic [63:0] per_reg;
    logic        reload;
    logic        armed;
    logic        pending;

    assign outstanding = outcome_q.size();

    task automatic halt_timer(inout outcome_t o);
        pending = 1'b0;
        if (armed)
        begin
            armed = 1'b0;
            o.compare_cancel = 1'b1;
        end
    endtask

    // Programs the compare once the deadline is inside the window, and requests a wake-up while more deadlines remain.
    task automatic scan_timer(input logic [63:0] now, inout outcome_t o);
        logic [63:0] lead_t;
        logic [63:0] expire;
        logic [63:0] prog;
        lead_t = 64'(lead);
        if (!pending)
            return;
        expire = (now < next_dl) ? next_dl - now : lead_t;
        if (expire <= 64'(win))
        begin
            prog = next_dl;
            if (expire <= lead_t)
                prog = now + lead_t;
            armed = 1'b1;
            if (hw_mode)
            begin
                next_dl = next_dl + per_reg;
                o.program_periodic = 1'b1;
                o.program_period = per_reg;
            end
            cur_dl = next_dl;
            o.program_valid = 1'b1;
            o.program_time = prog;
            if (per_reg == 0 || reload || hw_mode)
            begin
                pending = 1'b0;
                return;
            end
            next_dl = next_dl + per_reg;
            expire = expire + per_reg;
        end
        o.wake_valid = 1'b1;
        o.wake_delay = expire - 64'(win) / 64'd8;
    endtask

    // Counts late periods with rounding and reloads or disarms the timer.
    task automatic expire_timer(input logic [63:0] now, inout outcome_t o);
        logic [63:0] count;
        logic [63:0] late;
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] prog;
        logic [63:0] floor_t;
        count = 64'd1;
        if (!armed)
            return;
        if (per_reg != 0 && now >= cur_dl)
        begin
            late = now - cur_dl;
            if (late >= per_reg)
            begin
                n = late / per_reg;
                rem = late % per_reg;
                if (rem >= per_reg - per_reg / 64'd2)
                    n = n + 64'd1;
                cur_dl = cur_dl + n * per_reg;
                next_dl = next_dl + n * per_reg;
                count = (n >= COUNT_SAT) ? COUNT_SAT : n + 64'd1;
            end
        end
        if (hw_mode)
        begin
            next_dl = next_dl + per_reg;
            cur_dl = next_dl;
        end
        else if (reload)
        begin
            next_dl = next_dl + per_reg;
            cur_dl = next_dl;
            prog = next_dl;
            floor_t = now + 64'(lead);
            if (prog < floor_t)
                prog = floor_t;
            o.program_valid = 1'b1;
            o.program_time = prog;
        end
        else
        begin
            armed = 1'b0;
        end
        o.callback_valid = 1'b1;
        o.callback_count = count[16:0];
    endtask

    // Works out the outcome of one command transaction.
    task automatic timer_predict(input logic [pdt_pkg::CMD_W-1:0] cmd,
                                 input logic [63:0] now,
                                 input logic [63:0] val, input logic [63:0] per,
                                 input logic [pdt_pkg::DEN_W-1:0] den, input logic abs_t,
                                 output outcome_t o);
        o = '0;
        case (cmd)
            pdt_pkg::CMD_START:
            begin
                if (per != 0 && den != 8'd1)
                    o.status = 1'b1;
                else
                begin
                    if (!hw_mode)
                        val = val + per;
                    if (abs_t && val < now)
                        o.status = 1'b1;
                    else
                    begin
                        halt_timer(o);
                        next_dl = abs_t ? val : val + now;
                        per_reg = per;
                        if (per != 0)
                            reload = per < 64'(win);
                        pending = 1'b1;
                        scan_timer(now, o);
                    end
                end
            end
            pdt_pkg::CMD_STOP:   halt_timer(o);
            pdt_pkg::CMD_SCAN:   scan_timer(now, o);
            pdt_pkg::CMD_EXPIRY: expire_timer(now, o);
            pdt_pkg::CMD_DISC:
            begin
                halt_timer(o);
                o.callback_valid = 1'b1;
                o.callback_count = pdt_pkg::CB_DISC;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, field, want, got);
        mismatches++;
    endtask

    // Monitor: register writes, accepted commands, accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        if (!rst_n)
        begin
            hw_mode = 1'b0;
            lead = pdt_pkg::MIN_LEAD_RST;
            win = pdt_pkg::WINDOW_RST;
            next_dl = '0;
            cur_dl = '0;
            per_reg = '0;
            reload = 1'b0;
            armed = 1'b0;
            pending = 1'b0;
            mismatches = 0;
            outcome_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    pdt_pkg::REG_HW_PERIODIC: hw_mode = pwdata[0];
                    pdt_pkg::REG_MIN_LEAD:    lead = pwdata[pdt_pkg::LEAD_W-1:0];
                    pdt_pkg::REG_WINDOW:      win = pwdata[pdt_pkg::WIN_W-1:0];
                    default: ;
                endcase
            end
            if (request.valid && request.ready)
            begin
                timer_predict(request.command, request.now, request.value, request.period,
                              request.period_denominator, request.absolute, o);
                outcome_q.push_back(o);
            end
            if (result.valid && result.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected", $realtime);
                    mismatches++;
                end
                else
                begin
                    o = outcome_q.pop_front();
                    if (result.status !== o.status)
                        report_mismatch("status", o.status, result.status);
                    if (result.program_valid !== o.program_valid)
                        report_mismatch("program_valid", o.program_valid,
                                        result.program_valid);
                    if (result.program_time !== o.program_time)
                        report_mismatch("program_time", o.program_time, result.program_time);
                    if (result.program_periodic !== o.program_periodic)
                        report_mismatch("program_periodic", o.program_periodic,
                                        result.program_periodic);
                    if (result.program_period !== o.program_period)
                        report_mismatch("program_period", o.program_period,
                                        result.program_period);
                    if (result.compare_cancel !== o.compare_cancel)
                        report_mismatch("compare_cancel", o.compare_cancel,
                                        result.compare_cancel);
                    if (result.wake_valid !== o.wake_valid)
                        report_mismatch("wake_valid", o.wake_valid, result.wake_valid);
                    if (result.wake_delay !== o.wake_delay)
                        report_mismatch("wake_delay", o.wake_delay, result.wake_delay);
                    if (result.callback_valid !== o.callback_valid)
                        report_mismatch("callback_valid", o.callback_valid,
                                        result.callback_valid);
                    if (result.callback_count !== o.callback_count)
                        report_mismatch("callback_count", o.callback_count,
                                        result.callback_count);
                end
            end
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [pdt_pkg::ADDR_W-1:0] paddr;
    logic [pdt_pkg::DATA_W-1:0] pwdata;
    logic [pdt_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    int                         outstanding;
    int                         mismatches;
    logic                       calm;
    logic [63:0]                tnow;

    pdt_cmd_if cmd_ch ();
    pdt_res_if res_ch ();

    periodic_deadline_timer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .request (cmd_ch),
        .result  (res_ch)
    );

    pdt_scoreboard chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .request     (cmd_ch),
        .result      (res_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous upper bound on the whole run.
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Result side: stalls in random bursts until the closing phase.
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm || $urandom_range(0, 2) != 0)
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    // Sends one command transaction, with an occasional idle burst first.
    task automatic issue(input logic [pdt_pkg::CMD_W-1:0] cmd, input logic [63:0] now,
                         input logic [63:0] val, input logic [63:0] per,
                         input logic [pdt_pkg::DEN_W-1:0] den, input logic abs_t);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.now <= now;
        cmd_ch.value <= val;
        cmd_ch.period <= per;
        cmd_ch.period_denominator <= den;
        cmd_ch.absolute <= abs_t;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Register write, only once every outstanding result has come back.
    task automatic write_reg(input logic [1:0] idx, input logic [pdt_pkg::DATA_W-1:0] data);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Mostly well-formed timer traffic around a running clock, some noise.
    task automatic random_traffic(input int count);
        logic [63:0] per;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            tnow = tnow + $urandom_range(0, 3000000);
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 4))
                0: per = 64'd0;
                1: per = $urandom_range(1000, 3000000);
                2: per = $urandom_range(1, 400);
                3: per = $urandom_range(150000000, 400000000);
                default: per = $urandom_range(10000, 50000000);
            endcase
            if (pick < 20)
                issue(pdt_pkg::CMD_START, tnow,
                      $urandom_range(0, 5000000) + (pick[0] ? tnow : 64'd0),
                      per, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd1, pick[0]);
            else if (pick < 40)
                issue(pdt_pkg::CMD_SCAN, tnow, rand64(), rand64(), 8'($urandom),
                      1'($urandom));
            else if (pick < 72)
                issue(pdt_pkg::CMD_EXPIRY, tnow + (($urandom_range(0, 3) == 0) ?
                      64'($urandom) * 64'($urandom_range(1, 4000)) : 64'd0),
                      rand64(), rand64(), 8'($urandom), 1'($urandom));
            else if (pick < 80)
                issue(pdt_pkg::CMD_STOP, tnow, rand64(), rand64(), 8'($urandom),
                      1'($urandom));
            else if (pick < 85)
                issue(pdt_pkg::CMD_DISC, tnow, rand64(), rand64(), 8'($urandom),
                      1'($urandom));
            else
                issue(pdt_pkg::CMD_W'($urandom), rand64(), rand64(),
                      ($urandom_range(0, 1) == 0) ? rand64() : 64'd0,
                      8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        calm = 1'b0;
        tnow = 64'd1000000000;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= pdt_pkg::CMD_STOP;
        cmd_ch.now <= '0;
        cmd_ch.value <= '0;
        cmd_ch.period <= '0;
        cmd_ch.period_denominator <= '0;
        cmd_ch.absolute <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle commands, rejections, one-shot, late expiry, extremes.
        issue(pdt_pkg::CMD_SCAN, tnow, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_EXPIRY, tnow, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_START, tnow, 64'd5000, 64'd1000, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_START, tnow, 64'd5000, 64'd1000, 8'd255, 1'b0);
        issue(pdt_pkg::CMD_START, tnow, tnow - 64'd1, 64'd0, 8'd0, 1'b1);
        issue(pdt_pkg::CMD_START, tnow, tnow + 64'd3000, 64'd0, 8'd7, 1'b1);
        issue(pdt_pkg::CMD_EXPIRY, tnow + 64'd3000, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_START, tnow, 64'd500000000, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_SCAN, tnow + 64'd100000000, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_SCAN, tnow + 64'd400000000, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_STOP, tnow, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_START, tnow, 64'd20000, 64'd1000000, 8'd1, 1'b0);
        issue(pdt_pkg::CMD_EXPIRY, tnow + 64'd777777777, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_EXPIRY, tnow + 64'd900000000000, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_DISC, tnow, 64'd0, 64'd0, 8'd0, 1'b0);
        issue(pdt_pkg::CMD_START, tnow, 64'd1000, 64'd300000000, 8'd1, 1'b1);
        issue(pdt_pkg::CMD_START, '1, '1, '1, 8'd1, 1'b0);
        issue(pdt_pkg::CMD_SCAN, '1, '1, '1, '1, 1'b1);
        issue(pdt_pkg::CMD_START, 64'd0, '1, 64'd0, 8'd0, 1'b1);
        issue(pdt_pkg::CMD_EXPIRY, '1, '1, '1, '1, 1'b1);
        issue(pdt_pkg::CMD_STOP, '1, '1, '1, '1, 1'b1);
        issue(pdt_pkg::CMD_DISC + 3'd1, '1, '1, '1, '1, 1'b1);
        issue('1, 64'd0, 64'd0, 64'd0, 8'd0, 1'b0);

        random_traffic(90);

        write_reg(pdt_pkg::REG_HW_PERIODIC, 32'd1);
        random_traffic(100);

        write_reg(pdt_pkg::REG_MIN_LEAD, 32'd1);
        write_reg(pdt_pkg::REG_WINDOW, 32'd1);
        random_traffic(80);

        write_reg(pdt_pkg::REG_HW_PERIODIC, 32'd0);
        write_reg(pdt_pkg::REG_MIN_LEAD, 32'd1000000);
        write_reg(pdt_pkg::REG_WINDOW, 32'hFFFFFFFF);
        random_traffic(100);

        write_reg(pdt_pkg::REG_MIN_LEAD, 32'd2500);
        write_reg(pdt_pkg::REG_WINDOW, 32'd8000000);
        random_traffic(80);

        // Closing phase runs without idling on either side.
        calm = 1'b1;
        random_traffic(100);
        cmd_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
